// File: design/dsrv_pkg.sv
// Package for the dual-slot record validator: constants, types and the CRC-32 word update.
`default_nettype none

package dsrv_pkg;

    // Record layout: magic, DATA_WORDS data words, sequence, crc, commit.
    localparam int DATA_WORDS = 5;
    localparam int POS_SEQ    = DATA_WORDS + 1;
    localparam int POS_CRC    = DATA_WORDS + 2;
    localparam int POS_COMMIT = DATA_WORDS + 3;
    localparam int POS_DONE   = DATA_WORDS + 4;
    localparam int POS_W      = $clog2(POS_DONE + 1);

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos P_MAGIC = t_pos'(0);
    localparam t_pos P_SEQ   = t_pos'(POS_SEQ);
    localparam t_pos P_CRC   = t_pos'(POS_CRC);
    localparam t_pos P_DONE  = t_pos'(POS_DONE);

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_RESET  = 32'h5345_5431;
    localparam logic [31:0] COMMIT_RESET = 32'hC0FF_EE0A;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAGIC  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_COMMIT = t_cfg_idx'(1);

    typedef enum logic [1:0] {
        FAIL_NONE   = 2'd0,
        FAIL_MAGIC  = 2'd1,
        FAIL_CRC    = 2'd2,
        FAIL_COMMIT = 2'd3
    } t_fail;

    typedef enum logic [1:0] {
        LOAD_NONE = 2'd0,
        LOAD_A    = 2'd1,
        LOAD_B    = 2'd2
    } t_load;

    // Outcome of one completed record, handed from the record checker to the slot table.
    typedef struct packed {
        logic        valid;
        logic        slot;
        t_fail       fail;
        logic [31:0] seq;
    } t_commit;

    // The 32-bit reflected CRC update is linear over GF(2); row j selects the
    // bits of (acc ^ word) that are XORed into result bit j.
    typedef logic [31:0][31:0] t_crc_mat;

    function automatic t_crc_mat crc_matrix();
        t_crc_mat    m;
        logic [31:0] col;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            col = 32'd1 << i;
            for (int b = 0; b < 32; b++) begin
                col = col[0] ? ((col >> 1) ^ CRC_POLY) : (col >> 1);
            end
            for (int j = 0; j < 32; j++) begin
                m[j][i] = col[j];
            end
        end
        return m;
    endfunction

    localparam t_crc_mat CRC_MAT = crc_matrix();

    function automatic logic [31:0] crc_word(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] v;
        logic [31:0] r;
        v = acc ^ w;
        for (int j = 0; j < 32; j++) begin
            r[j] = ^(v & CRC_MAT[j]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/dsrv_ifs.sv
// Handshake interfaces for the record word, result and configuration channels.
`default_nettype none

interface dsrv_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        slot;
    logic        first;

    modport source (output valid, output word, output slot, output first, input ready);
    modport sink   (input valid, input word, input slot, input first, output ready);
endinterface

interface dsrv_out_if;
    logic        valid;
    logic        ready;
    logic        record_slot;
    logic [1:0]  fail_code;
    logic        valid_a;
    logic        valid_b;
    logic [1:0]  load_choice;
    logic [31:0] load_seq;
    logic        write_slot;
    logic [31:0] next_seq;

    modport source (output valid, output record_slot, output fail_code, output valid_a,
                    output valid_b, output load_choice, output load_seq,
                    output write_slot, output next_seq, input ready);
    modport sink   (input valid, input record_slot, input fail_code, input valid_a,
                    input valid_b, input load_choice, input load_seq,
                    input write_slot, input next_seq, output ready);
endinterface

interface dsrv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dsrv_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/dsrv_cfg_regs.sv
// Configuration registers: expected magic and commit words.
`default_nettype none

module dsrv_cfg_regs (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dsrv_cfg_if.sink     i_cfg,
    output logic [31:0]  o_magic,
    output logic [31:0]  o_commit
);

    logic [31:0] r_magic;
    logic [31:0] r_commit;

    assign i_cfg.ready = 1'b1;
    assign o_magic     = r_magic;
    assign o_commit    = r_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic  <= dsrv_pkg::MAGIC_RESET;
            r_commit <= dsrv_pkg::COMMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dsrv_pkg::CFG_MAGIC:  r_magic  <= i_cfg.data;
                dsrv_pkg::CFG_COMMIT: r_commit <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/dsrv_record.sv
// Input register and record checker: word position, running CRC, magic, CRC and commit checks.
`default_nettype none

module dsrv_record (
    input  wire                i_clk,
    input  wire                i_rst_n,
    dsrv_in_if.sink            i_req,
    input  wire                i_advance,
    input  wire  [31:0]        i_magic,
    input  wire  [31:0]        i_commit,
    output dsrv_pkg::t_commit  o_evt
);

    logic                 r_in_valid;
    logic [31:0]          r_word;
    logic                 r_slot;
    logic                 r_first;

    logic [31:0]          r_crc;
    dsrv_pkg::t_pos       r_pos;
    logic                 r_magic_ok;
    logic                 r_crc_ok;
    logic [31:0]          r_seq;

    logic [31:0]          n_crc;
    dsrv_pkg::t_pos       n_pos;
    logic                 n_magic_ok;
    logic                 n_crc_ok;
    logic [31:0]          n_seq;

    logic                 fire;
    dsrv_pkg::t_pos       pos_eff;
    logic [31:0]          crc_eff;

    assign fire        = r_in_valid && i_advance;
    assign i_req.ready = !r_in_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_word  <= i_req.word;
            r_slot  <= i_req.slot;
            r_first <= i_req.first;
        end
    end

    always_comb begin
        pos_eff    = r_first ? dsrv_pkg::P_MAGIC : r_pos;
        crc_eff    = r_first ? dsrv_pkg::CRC_INIT : r_crc;
        n_crc      = crc_eff;
        n_pos      = pos_eff;
        n_magic_ok = r_magic_ok;
        n_crc_ok   = r_crc_ok;
        n_seq      = r_seq;
        o_evt      = '0;
        o_evt.slot = r_slot;
        o_evt.seq  = r_seq;
        o_evt.fail = dsrv_pkg::FAIL_NONE;

        if (pos_eff >= dsrv_pkg::P_DONE) begin
            // Trailing words after a commit are dropped until the next first word.
        end else if (pos_eff < dsrv_pkg::P_CRC) begin
            if (pos_eff == dsrv_pkg::P_MAGIC) begin
                n_magic_ok = (r_word == i_magic);
            end
            if (pos_eff == dsrv_pkg::P_SEQ) begin
                n_seq = r_word;
            end
            n_crc = dsrv_pkg::crc_word(crc_eff, r_word);
            n_pos = pos_eff + dsrv_pkg::t_pos'(1);
        end else if (pos_eff == dsrv_pkg::P_CRC) begin
            n_crc_ok = (~crc_eff == r_word);
            n_pos    = pos_eff + dsrv_pkg::t_pos'(1);
        end else begin
            n_pos       = dsrv_pkg::P_DONE;
            o_evt.valid = fire;
            if (!r_magic_ok) begin
                o_evt.fail = dsrv_pkg::FAIL_MAGIC;
            end else if (!r_crc_ok) begin
                o_evt.fail = dsrv_pkg::FAIL_CRC;
            end else if (r_word != i_commit) begin
                o_evt.fail = dsrv_pkg::FAIL_COMMIT;
            end else begin
                o_evt.fail = dsrv_pkg::FAIL_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= dsrv_pkg::CRC_INIT;
            r_pos      <= dsrv_pkg::P_MAGIC;
            r_magic_ok <= 1'b0;
            r_crc_ok   <= 1'b0;
            r_seq      <= '0;
        end else if (fire) begin
            r_crc      <= n_crc;
            r_pos      <= n_pos;
            r_magic_ok <= n_magic_ok;
            r_crc_ok   <= n_crc_ok;
            r_seq      <= n_seq;
        end
    end

endmodule

`default_nettype wire

// File: design/dsrv_select.sv
// Slot table, load and write slot selection, and the result register.
`default_nettype none

module dsrv_select (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  dsrv_pkg::t_commit  i_evt,
    output logic               o_advance,
    dsrv_out_if.source         o_res
);

    logic                 r_va;
    logic                 r_vb;
    logic [31:0]          r_sa;
    logic [31:0]          r_sb;

    logic                 n_va;
    logic                 n_vb;
    logic [31:0]          n_sa;
    logic [31:0]          n_sb;

    logic                 r_out_valid;
    logic                 r_rec_slot;
    dsrv_pkg::t_fail      r_fail;
    logic                 r_out_va;
    logic                 r_out_vb;
    dsrv_pkg::t_load      r_choice;
    logic [31:0]          r_lseq;
    logic                 r_wslot;
    logic [31:0]          r_nseq;

    logic                 rec_ok;
    dsrv_pkg::t_load      choice;
    logic [31:0]          lseq;
    logic                 wslot;

    assign o_advance = !r_out_valid || o_res.ready;
    assign rec_ok    = (i_evt.fail == dsrv_pkg::FAIL_NONE);

    always_comb begin
        n_va = r_va;
        n_vb = r_vb;
        n_sa = r_sa;
        n_sb = r_sb;
        if (i_evt.valid) begin
            if (i_evt.slot) begin
                n_vb = rec_ok;
                n_sb = rec_ok ? i_evt.seq : 32'd0;
            end else begin
                n_va = rec_ok;
                n_sa = rec_ok ? i_evt.seq : 32'd0;
            end
        end

        if (n_va && n_vb) begin
            choice = (n_sb >= n_sa) ? dsrv_pkg::LOAD_B : dsrv_pkg::LOAD_A;
            lseq   = (n_sb >= n_sa) ? n_sb : n_sa;
            wslot  = (n_sb <= n_sa);
        end else if (n_va) begin
            choice = dsrv_pkg::LOAD_A;
            lseq   = n_sa;
            wslot  = 1'b1;
        end else if (n_vb) begin
            choice = dsrv_pkg::LOAD_B;
            lseq   = n_sb;
            wslot  = 1'b0;
        end else begin
            choice = dsrv_pkg::LOAD_NONE;
            lseq   = 32'd0;
            wslot  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_sa        <= '0;
            r_sb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_evt.valid) begin
                r_va <= n_va;
                r_vb <= n_vb;
                r_sa <= n_sa;
                r_sb <= n_sb;
            end
            if (o_advance) begin
                r_out_valid <= i_evt.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_evt.valid) begin
            r_rec_slot <= i_evt.slot;
            r_fail     <= i_evt.fail;
            r_out_va   <= n_va;
            r_out_vb   <= n_vb;
            r_choice   <= choice;
            r_lseq     <= lseq;
            r_wslot    <= wslot;
            // With no valid slot lseq is zero, so this also gives the default of one.
            r_nseq     <= lseq + 32'd1;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.record_slot = r_rec_slot;
    assign o_res.fail_code   = r_fail;
    assign o_res.valid_a     = r_out_va;
    assign o_res.valid_b     = r_out_vb;
    assign o_res.load_choice = r_choice;
    assign o_res.load_seq    = r_lseq;
    assign o_res.write_slot  = r_wslot;
    assign o_res.next_seq    = r_nseq;

    a_none_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_choice == dsrv_pkg::LOAD_NONE) |-> (r_lseq == 32'd0 && r_nseq == 32'd1))
        else $error("no slot chosen but sequence outputs are not the defaults");

    a_next_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_choice != dsrv_pkg::LOAD_NONE) |-> (r_nseq == r_lseq + 32'd1))
        else $error("next sequence does not follow the loaded sequence");

    a_ok_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fail == dsrv_pkg::FAIL_NONE) |->
            ((r_rec_slot && r_out_vb) || (!r_rec_slot && r_out_va)))
        else $error("valid record did not mark its slot valid");

    a_invalid_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_va |-> r_sa == 32'd0) and (!r_vb |-> r_sb == 32'd0))
        else $error("invalid slot holds a nonzero sequence");

endmodule

`default_nettype wire

// File: design/dual_slot_record_validator.sv
// Top level of the dual-slot record validator.
// An accepted record word is held in the input register and checked from there; for a
// commit word the result request is valid once the result register takes the outcome.
// Throughput: one word per cycle; a result that waits on the sink stalls all input words.
// Reset (i_rst_n low, synchronous) empties both registers, clears the slot table, sets the
// running CRC to all ones and the word position to the magic word, and reloads the defaults.
`default_nettype none

module dual_slot_record_validator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dsrv_in_if.sink    i_req,
    dsrv_cfg_if.sink   i_cfg,
    dsrv_out_if.source o_res
);

    // The datapath has two register stages. The record checker holds the accepted
    // word in its input register; from there the word updates the position,
    // the CRC and the magic, sequence and CRC checks. On the commit word the checker
    // hands a commit event to the slot table, which updates the slot's valid flag and
    // sequence and computes load and write selection into the result register.
    //
    // Both stages move together whenever the result register is empty or its request
    // is being taken, so a stalled result only holds the pipe when the sink is slow.
    // Words that produce no result still pass through the stages in order.

    logic              advance;
    logic [31:0]       magic;
    logic [31:0]       commit;
    dsrv_pkg::t_commit evt;

    // Expected magic and commit words; the user writes them only while no record is in flight; not enforced.
    dsrv_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_magic  (magic),
        .o_commit (commit)
    );

    // Record position tracking, CRC-32 over magic through sequence, and the
    // failure priority (bad magic, then CRC mismatch, then missing commit).
    dsrv_record u_record (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .i_magic   (magic),
        .i_commit  (commit),
        .o_evt     (evt)
    );

    // Per-slot valid flags and sequences; newer sequence is loaded with B winning
    // ties, and the older slot is the one to overwrite next (B on a tie as well).
    dsrv_select u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (evt),
        .o_advance (advance),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the dual-slot record validator: records, registers and stalls.
`default_nettype none

module tb_top;

    // Slot codes as they appear on the slot, record_slot and write_slot fields.
    localparam logic SLOT_A = 1'b0;
    localparam logic SLOT_B = 1'b1;

    // The watchdog ends the run once this many cycles pass with no handshake on any channel.
    // The longest quiet stretch is the deliberate output hold-off.
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_WORDS = 1420;

    logic i_clk;
    logic i_rst_n;

    dsrv_in_if  req_if ();
    dsrv_cfg_if cfg_if ();
    dsrv_out_if res_if ();

    dual_slot_record_validator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // One expected outcome request, in the order the block has to deliver them.
    typedef struct {
        logic              slot;
        dsrv_pkg::t_fail   fail;
        logic              va;
        logic              vb;
        dsrv_pkg::t_load   choice;
        logic [31:0]       lseq;
        logic              wslot;
        logic [31:0]       nseq;
    } t_record_outcome;

    t_record_outcome outcomes_due [$];

    // Shadow copy of the register file, written when a register write request is accepted.
    logic [31:0] magic_reg  = dsrv_pkg::MAGIC_RESET;
    logic [31:0] commit_reg = dsrv_pkg::COMMIT_RESET;

    // Shadow copy of the record checker and of the slot table, at their reset values.
    logic [31:0] rec_crc      = dsrv_pkg::CRC_INIT;
    int          rec_pos      = 0;
    logic        rec_magic_ok = 1'b0;
    logic [31:0] rec_seq      = 32'd0;
    logic        rec_crc_ok   = 1'b0;
    logic        rec_slot_valid [2] = '{1'b0, 1'b0};
    logic [31:0] rec_slot_seq   [2] = '{32'd0, 32'd0};

    // Run statistics and the error count.
    int n_errors     = 0;
    int n_words      = 0;
    int n_results    = 0;
    int n_cfg_writes = 0;
    int fail_tally [4] = '{0, 0, 0, 0};

    // Idling control for the sender and the receiver, and the watchdog's quiet count.
    bit no_idle   = 1'b0;
    int sink_hold = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // One word of the reflected CRC-32, one bit at a time, low bit first.
    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [31:0] w);
        logic [31:0] r;
        r = acc ^ w;
        for (int b = 0; b < 32; b++) begin
            r = r[0] ? ((r >> 1) ^ dsrv_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Follows one accepted record word through the checker. Words up to the sequence feed the
    // CRC, the CRC word is compared, and the commit word closes the record: it settles the
    // slot it names and queues the outcome the block must report.
    function automatic void track_record_word(input logic [31:0] w, input logic s,
                                              input logic f);
        t_record_outcome o;
        logic            va;
        logic            vb;
        logic [31:0]     sa;
        logic [31:0]     sb;
        if (f) begin
            rec_pos = 0;
            rec_crc = dsrv_pkg::CRC_INIT;
        end
        // Words after a commit and before the next first marker leave no trace.
        if (rec_pos >= dsrv_pkg::POS_DONE) return;
        if (rec_pos < dsrv_pkg::POS_CRC) begin
            if (rec_pos == 0) rec_magic_ok = (w == magic_reg);
            if (rec_pos == dsrv_pkg::POS_SEQ) rec_seq = w;
            rec_crc = crc32_step(rec_crc, w);
            rec_pos++;
            return;
        end
        if (rec_pos == dsrv_pkg::POS_CRC) begin
            rec_crc_ok = (~rec_crc == w);
            rec_pos++;
            return;
        end

        // Commit word. Bad magic outranks a CRC mismatch, which outranks a missing commit.
        rec_pos = dsrv_pkg::POS_DONE;
        if (!rec_magic_ok) begin
            o.fail = dsrv_pkg::FAIL_MAGIC;
        end else if (!rec_crc_ok) begin
            o.fail = dsrv_pkg::FAIL_CRC;
        end else if (w != commit_reg) begin
            o.fail = dsrv_pkg::FAIL_COMMIT;
        end else begin
            o.fail = dsrv_pkg::FAIL_NONE;
        end
        // Only the commit word's slot field counts; a failed record empties its slot.
        rec_slot_valid[s] = (o.fail == dsrv_pkg::FAIL_NONE);
        rec_slot_seq[s]   = (o.fail == dsrv_pkg::FAIL_NONE) ? rec_seq : 32'd0;

        va = rec_slot_valid[0];
        vb = rec_slot_valid[1];
        sa = rec_slot_seq[0];
        sb = rec_slot_seq[1];
        if (va && vb) begin
            // The newer sequence is loaded and the older slot is overwritten; on a tie B is both.
            if (sb >= sa) begin
                o.choice = dsrv_pkg::LOAD_B;
                o.lseq   = sb;
            end else begin
                o.choice = dsrv_pkg::LOAD_A;
                o.lseq   = sa;
            end
            o.wslot = (sb <= sa) ? SLOT_B : SLOT_A;
        end else if (va) begin
            o.choice = dsrv_pkg::LOAD_A;
            o.lseq   = sa;
            o.wslot  = SLOT_B;
        end else if (vb) begin
            o.choice = dsrv_pkg::LOAD_B;
            o.lseq   = sb;
            o.wslot  = SLOT_A;
        end else begin
            o.choice = dsrv_pkg::LOAD_NONE;
            o.lseq   = 32'd0;
            o.wslot  = SLOT_A;
        end
        // With no valid slot the next save starts at one; otherwise it wraps modulo 2^32.
        o.nseq = (va || vb) ? o.lseq + 32'd1 : 32'd1;
        o.slot = s;
        o.va   = va;
        o.vb   = vb;
        fail_tally[o.fail]++;
        outcomes_due.push_back(o);
    endfunction

    // Offers one record word and holds it until the block takes the request. Valid stays high
    // after acceptance so that back-to-back words need no second assignment in one step.
    task automatic push_word(input logic [31:0] w, input logic s, input logic f);
        if (!no_idle) begin
            while ($urandom_range(99) < 34) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.word  <= w;
        req_if.slot  <= s;
        req_if.first <= f;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        track_record_word(w, s, f);
        n_words++;
    endtask

    // Sends a whole record. Words before the commit carry random slot fields, since only the
    // commit word's slot is meant to count. crc_err flips bits of the stored CRC.
    task automatic send_record(input logic s, input logic [31:0] magic, input logic [31:0] seq,
                               input logic [31:0] crc_err, input logic [31:0] commit,
                               input logic lead_first);
        logic [31:0] acc;
        logic [31:0] w;
        acc = crc32_step(dsrv_pkg::CRC_INIT, magic);
        push_word(magic, 1'($urandom_range(1)), lead_first);
        for (int i = 0; i < dsrv_pkg::DATA_WORDS; i++) begin
            w   = $urandom;
            acc = crc32_step(acc, w);
            push_word(w, 1'($urandom_range(1)), 1'b0);
        end
        acc = crc32_step(acc, seq);
        push_word(seq, 1'($urandom_range(1)), 1'b0);
        push_word(~acc ^ crc_err, 1'($urandom_range(1)), 1'b0);
        push_word(commit, s, 1'b0);
    endtask

    task automatic send_good(input logic s, input logic [31:0] seq);
        send_record(s, magic_reg, seq, 32'd0, commit_reg, 1'b1);
    endtask

    // A few words that belong to no record: trailing words or a stray first marker.
    task automatic send_noise(input int count, input bit allow_first);
        for (int i = 0; i < count; i++) begin
            push_word($urandom, 1'($urandom_range(1)),
                      allow_first ? 1'($urandom_range(3) == 0) : 1'b0);
        end
    endtask

    // Lets the block run dry: no word offered until every outcome has arrived, then it waits on
    // so that a word still in the checker stage has been taken in as well.
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (outcomes_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register through its own channel; only ever called with the block idle.
    task automatic write_reg(input dsrv_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        if (idx == dsrv_pkg::CFG_MAGIC) begin
            magic_reg = val;
        end else begin
            commit_reg = val;
        end
        n_cfg_writes++;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sequence numbers that make the slot comparison interesting: ties with what is stored,
    // neighbors of it, the ends of the range, small values and anything at all.
    function automatic logic [31:0] pick_seq();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 32'd0;
            1: v = 32'hFFFF_FFFF;
            2: v = rec_slot_seq[$urandom_range(1)];
            3: v = rec_slot_seq[$urandom_range(1)] + 32'd1;
            4: v = rec_slot_seq[$urandom_range(1)] - 32'd1;
            7: v = $urandom;
            default: v = 32'($urandom_range(20));
        endcase
        return v;
    endfunction

    // Reset leaves the checker at the magic word, so a record without a first marker still
    // starts there. This has to be the very first traffic of the run.
    task automatic test_no_first_after_reset();
        send_record(SLOT_A, magic_reg, 32'd5, 32'd0, commit_reg, 1'b0);
        settle();
    endtask

    // Every failure kind, their precedence, the slot choice with ties and wrap, and the
    // handling of trailing and truncated records.
    task automatic test_directed_outcomes();
        send_good(SLOT_B, 32'd5);                                  // tie, B is loaded
        send_good(SLOT_A, 32'hFFFF_FFFF);                          // A newer, next wraps to 0
        send_record(SLOT_B, ~magic_reg, 32'd9, 32'd1, commit_reg, 1'b1);  // magic over CRC
        send_record(SLOT_A, magic_reg, 32'd9, 32'h8000_0000, ~commit_reg, 1'b1);  // CRC first
        send_record(SLOT_A, magic_reg, 32'd9, 32'd0, ~commit_reg, 1'b1);  // not committed
        send_good(SLOT_B, 32'd0);                                  // only B valid
        send_noise(3, 1'b0);                                       // ignored after commit
        push_word(magic_reg, SLOT_A, 1'b1);                        // truncated record
        send_noise(3, 1'b0);
        send_good(SLOT_A, 32'd1);
        settle();
    endtask

    // Both registers at both ends of their range, then random values, then the defaults.
    task automatic test_register_extremes();
        write_reg(dsrv_pkg::CFG_MAGIC, 32'h0000_0000);
        write_reg(dsrv_pkg::CFG_COMMIT, 32'hFFFF_FFFF);
        send_good(SLOT_A, 32'd7);
        send_record(SLOT_B, dsrv_pkg::MAGIC_RESET, 32'd8, 32'd0, commit_reg, 1'b1);
        settle();
        write_reg(dsrv_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(dsrv_pkg::CFG_COMMIT, 32'h0000_0000);
        send_good(SLOT_B, 32'd3);
        send_record(SLOT_A, magic_reg, 32'd4, 32'd0, dsrv_pkg::COMMIT_RESET, 1'b1);
        settle();
        write_reg(dsrv_pkg::CFG_MAGIC, $urandom);
        write_reg(dsrv_pkg::CFG_COMMIT, $urandom);
        send_good(SLOT_A, 32'd2);
        send_good(SLOT_B, 32'd2);
        settle();
        write_reg(dsrv_pkg::CFG_MAGIC, dsrv_pkg::MAGIC_RESET);
        write_reg(dsrv_pkg::CFG_COMMIT, dsrv_pkg::COMMIT_RESET);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering words, so a
    // finished result waits, the next commit backs up and the block stalls its input.
    task automatic test_output_stall();
        sink_hold = 400;
        no_idle   = 1'b1;
        repeat (6) send_good(1'($urandom_range(1)), pick_seq());
        no_idle = 1'b0;
        settle();
    endtask

    // Mostly well-formed records with random content, some broken ones and some noise. The
    // opening stretch runs without idling on either side; registers change between phases.
    task automatic test_random_records();
        int start_words;
        int rec_count;
        int kind;
        logic s;
        start_words = n_words;
        rec_count   = 0;
        no_idle     = 1'b1;
        while (n_words - start_words < RANDOM_WORDS) begin
            if (n_words - start_words > 250) no_idle = 1'b0;
            if (rec_count % 40 == 39) begin
                settle();
                case ($urandom_range(3))
                    0: write_reg(dsrv_pkg::t_cfg_idx'($urandom_range(1)), $urandom);
                    1: write_reg(dsrv_pkg::CFG_MAGIC, dsrv_pkg::MAGIC_RESET);
                    2: write_reg(dsrv_pkg::CFG_COMMIT, dsrv_pkg::COMMIT_RESET);
                    default: write_reg(dsrv_pkg::t_cfg_idx'($urandom_range(1)),
                                       $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0);
                endcase
            end
            s    = 1'($urandom_range(1));
            kind = $urandom_range(99);
            if (kind < 64) begin
                send_good(s, pick_seq());
                if ($urandom_range(9) == 0) send_noise($urandom_range(1, 3), 1'b0);
            end else if (kind < 72) begin
                send_record(s, magic_reg ^ (32'd1 << $urandom_range(31)), pick_seq(),
                            $urandom_range(1) ? 32'd0 : $urandom, commit_reg, 1'b1);
            end else if (kind < 80) begin
                send_record(s, magic_reg, pick_seq(), 32'd1 << $urandom_range(31),
                            $urandom_range(1) ? commit_reg : ~commit_reg, 1'b1);
            end else if (kind < 87) begin
                send_record(s, magic_reg, pick_seq(), 32'd0,
                            commit_reg ^ (32'd1 << $urandom_range(31)), 1'b1);
            end else if (kind < 94) begin
                push_word($urandom_range(1) ? magic_reg : $urandom, s, 1'b1);
                send_noise($urandom_range(1, dsrv_pkg::POS_COMMIT - 1), 1'b0);
            end else begin
                send_noise($urandom_range(1, 4), 1'b1);
            end
            rec_count++;
        end
        settle();
    endtask

    // Compares one field of a result with its expectation.
    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Result checker: each accepted result request is matched with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_record_outcome exp_o;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            n_results++;
            if (outcomes_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual slot %0d fail %0d",
                         $time, res_if.record_slot, res_if.fail_code);
                n_errors++;
            end else begin
                exp_o = outcomes_due.pop_front();
                check_field("record_slot", 32'(exp_o.slot), 32'(res_if.record_slot));
                check_field("fail_code", 32'(exp_o.fail), 32'(res_if.fail_code));
                check_field("valid_a", 32'(exp_o.va), 32'(res_if.valid_a));
                check_field("valid_b", 32'(exp_o.vb), 32'(res_if.valid_b));
                check_field("load_choice", 32'(exp_o.choice), 32'(res_if.load_choice));
                check_field("load_seq", exp_o.lseq, res_if.load_seq);
                check_field("write_slot", 32'(exp_o.wslot), 32'(res_if.write_slot));
                check_field("next_seq", exp_o.nseq, res_if.next_seq);
            end
        end
    end

    // Receiver: random stalls, none during the quiet stretch, and a counted hold-off on request.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                res_if.ready <= 1'b0;
                sink_hold--;
            end else if (no_idle) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 34);
            end
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d outcomes still due",
                     $time, STALL_LIMIT, outcomes_due.size());
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence. Reset is applied once, at the start, and every input starts known.
    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.word  <= 32'd0;
        req_if.slot  <= SLOT_A;
        req_if.first <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= dsrv_pkg::CFG_MAGIC;
        cfg_if.data  <= 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_first_after_reset();
        test_directed_outcomes();
        test_register_extremes();
        test_output_stall();
        test_random_records();

        if (outcomes_due.size() != 0) begin
            $display("%0t: %0d outcomes never arrived", $time, outcomes_due.size());
            n_errors++;
        end
        $display("Covered %0d record words and %0d results: %0d valid, %0d bad magic,",
                 n_words, n_results, fail_tally[dsrv_pkg::FAIL_NONE],
                 fail_tally[dsrv_pkg::FAIL_MAGIC]);
        $display("%0d CRC mismatches, %0d uncommitted, over %0d register writes; %0d errors.",
                 fail_tally[dsrv_pkg::FAIL_CRC], fail_tally[dsrv_pkg::FAIL_COMMIT],
                 n_cfg_writes, n_errors);
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
